FILE: src/assert_macros.svh
// Assertion macros used by the replacer datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SCPR_ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("scpr assertion failed");

// Next-cycle implication, disabled during reset.
`define SCPR_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("scpr assertion failed");

`endif

FILE: src/scpr_pkg.sv
// Shared types and constants for the second-chance page replacer.
package scpr_pkg;

    localparam int FRAME_COUNT_DEF = 3;
    localparam int PAGE_BITS_DEF   = 16;

    localparam int PAGE_W  = 16;
    localparam int FRAME_W = 3;
    localparam int COUNT_W = 32;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOKUP,
        S_SWEEP,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load_page;
        logic lookup;
        logic sweep;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic resolved;
        logic victim;
        logic out_free;
    } t_dp_stat;

endpackage

FILE: src/scpr_ctrl.sv
// Controller state machine: sequences lookup, clock sweep and result hand-off.
module scpr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  scpr_pkg::t_dp_stat i_stat,
    output scpr_pkg::t_dp_cmd  o_cmd
);

    scpr_pkg::t_state r_state;
    scpr_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= scpr_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            scpr_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_state = scpr_pkg::S_LOOKUP;
                end
            end
            scpr_pkg::S_LOOKUP: begin
                n_state = i_stat.resolved ? scpr_pkg::S_DONE : scpr_pkg::S_SWEEP;
            end
            scpr_pkg::S_SWEEP: begin
                if (i_stat.victim) begin
                    n_state = scpr_pkg::S_DONE;
                end
            end
            scpr_pkg::S_DONE: begin
                if (i_stat.out_free) begin
                    n_state = scpr_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = scpr_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            scpr_pkg::S_IDLE: begin
                o_ready         = 1'b1;
                o_cmd.load_page = i_valid;
            end
            scpr_pkg::S_LOOKUP: begin
                o_cmd.lookup = 1'b1;
            end
            scpr_pkg::S_SWEEP: begin
                o_cmd.sweep = 1'b1;
            end
            scpr_pkg::S_DONE: begin
                o_cmd.out_load = i_stat.out_free;
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

endmodule

FILE: src/scpr_dp.sv
// Datapath: frame table, clock hand, fault counter and result register.
`include "assert_macros.svh"

module scpr_dp #(
    parameter int FRAME_COUNT = scpr_pkg::FRAME_COUNT_DEF,
    parameter int PAGE_BITS   = scpr_pkg::PAGE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  scpr_pkg::t_dp_cmd             i_cmd,
    output scpr_pkg::t_dp_stat            o_stat,
    input  logic [scpr_pkg::PAGE_W-1:0]   i_page_number,
    input  logic                          i_ready,
    output logic                          o_valid,
    output logic                          o_hit,
    output logic                          o_fault,
    output logic [scpr_pkg::FRAME_W-1:0]  o_frame_used,
    output logic                          o_evicted_valid,
    output logic [scpr_pkg::PAGE_W-1:0]   o_evicted_page,
    output logic [scpr_pkg::COUNT_W-1:0]  o_fault_total
);

    localparam int KEEP_W = (PAGE_BITS < scpr_pkg::PAGE_W) ? PAGE_BITS : scpr_pkg::PAGE_W;
    localparam int IDX_W  = $clog2(FRAME_COUNT);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_COUNT - 1);

    logic [KEEP_W-1:0]           r_page [FRAME_COUNT];
    logic [FRAME_COUNT-1:0]      r_valid;
    logic [FRAME_COUNT-1:0]      r_bit;
    logic [IDX_W-1:0]            r_hand;
    logic [scpr_pkg::COUNT_W-1:0] r_fault_total;
    logic [KEEP_W-1:0]           r_page_in;

    logic                        r_res_hit;
    logic [IDX_W-1:0]            r_res_frame;
    logic                        r_res_ev_valid;
    logic [KEEP_W-1:0]           r_res_ev_page;

    logic                        r_o_valid;
    logic                        r_o_hit;
    logic [IDX_W-1:0]            r_o_frame;
    logic                        r_o_ev_valid;
    logic [KEEP_W-1:0]           r_o_ev_page;
    logic [scpr_pkg::COUNT_W-1:0] r_o_total;

    logic                        hit_found;
    logic [IDX_W-1:0]            hit_idx;
    logic                        empty_found;
    logic [IDX_W-1:0]            empty_idx;
    logic [IDX_W-1:0]            hand_next;
    logic                        victim;
    logic                        fault_done;
    logic [scpr_pkg::COUNT_W-1:0] n_fault_total;

    // Parallel match and lowest-empty search; lowest index wins.
    always_comb begin
        hit_found   = 1'b0;
        hit_idx     = '0;
        empty_found = 1'b0;
        empty_idx   = '0;
        for (int f = FRAME_COUNT - 1; f >= 0; f--) begin
            if (r_valid[f] && (r_page[f] == r_page_in)) begin
                hit_found = 1'b1;
                hit_idx   = IDX_W'(f);
            end
            if (!r_valid[f]) begin
                empty_found = 1'b1;
                empty_idx   = IDX_W'(f);
            end
        end
    end

    assign hand_next  = (r_hand == LAST_IDX) ? '0 : r_hand + 1'b1;
    assign victim     = !r_bit[r_hand];
    assign fault_done = (i_cmd.lookup && !hit_found && empty_found) ||
                        (i_cmd.sweep && victim);
    assign n_fault_total = (r_fault_total == '1) ? r_fault_total : r_fault_total + 1'b1;

    assign o_stat.resolved = hit_found || empty_found;
    assign o_stat.victim   = victim;
    assign o_stat.out_free = !r_o_valid || i_ready;

    // Page store: no reset, read only while the frame is valid.
    always_ff @(posedge i_clk) begin
        if (i_cmd.lookup && !hit_found && empty_found) begin
            r_page[empty_idx] <= r_page_in;
        end else if (i_cmd.sweep && victim) begin
            r_page[r_hand] <= r_page_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_page) begin
            r_page_in <= i_page_number[KEEP_W-1:0];
        end
        if (i_cmd.lookup) begin
            r_res_hit      <= hit_found;
            r_res_frame    <= hit_found ? hit_idx : empty_idx;
            r_res_ev_valid <= 1'b0;
            r_res_ev_page  <= '0;
        end else if (i_cmd.sweep && victim) begin
            r_res_hit      <= 1'b0;
            r_res_frame    <= r_hand;
            r_res_ev_valid <= 1'b1;
            r_res_ev_page  <= r_page[r_hand];
        end
        if (i_cmd.out_load) begin
            r_o_hit      <= r_res_hit;
            r_o_frame    <= r_res_frame;
            r_o_ev_valid <= r_res_ev_valid;
            r_o_ev_page  <= r_res_ev_page;
            r_o_total    <= r_fault_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid       <= '0;
            r_bit         <= '0;
            r_hand        <= '0;
            r_fault_total <= '0;
            r_o_valid     <= 1'b0;
        end else begin
            if (i_cmd.lookup) begin
                if (hit_found) begin
                    r_bit[hit_idx] <= 1'b1;
                end else if (empty_found) begin
                    r_valid[empty_idx] <= 1'b1;
                    r_bit[empty_idx]   <= 1'b0;
                end
            end
            if (i_cmd.sweep) begin
                r_bit[r_hand] <= 1'b0;
                r_hand        <= hand_next;
            end
            if (fault_done) begin
                r_fault_total <= n_fault_total;
            end
            if (i_cmd.out_load) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_valid         = r_o_valid;
    assign o_hit           = r_o_hit;
    assign o_fault         = !r_o_hit;
    assign o_frame_used    = scpr_pkg::FRAME_W'(r_o_frame);
    assign o_evicted_valid = r_o_ev_valid;
    assign o_evicted_page  = scpr_pkg::PAGE_W'(r_o_ev_page);
    assign o_fault_total   = r_o_total;

    `SCPR_ASSERT_IMPLY(a_sweep_full, i_clk, i_rst_n, i_cmd.sweep, &r_valid)
    `SCPR_ASSERT_NEXT(a_hand_moves, i_clk, i_rst_n, i_cmd.sweep, r_hand != $past(r_hand))
    `SCPR_ASSERT_NEXT(a_count_step, i_clk, i_rst_n, fault_done && (r_fault_total != '1),
        r_fault_total == $past(r_fault_total) + 1'b1)
    `SCPR_ASSERT_IMPLY(a_evict_is_fault, i_clk, i_rst_n, r_o_valid && r_o_ev_valid, !r_o_hit)

endmodule

FILE: src/second_chance_page_replacer_core.sv
// Second-chance (clock) page replacer, top level.
//
// One page reference per input beat, one result beat per reference. An
// input beat is taken only while the controller is idle; a reference then
// goes through the parallel tag match against all frames in the lookup
// state, and a miss with every frame full walks the clock hand one frame
// per cycle, up to FRAME_COUNT+1 steps. For a hit or a fill of an empty
// frame the result register is loaded in the done state that follows the
// lookup; when a victim is swept for, the sweep state lies between them.
// In the done state the load waits until the result register is free, and
// the controller then returns to idle for the next beat. The result
// register lets the next reference be taken while a result still waits
// downstream. Page numbers are compared on their low PAGE_BITS bits (at
// most PAGE_W); the fault total saturates at all ones.
module second_chance_page_replacer_core #(
    parameter int FRAME_COUNT = scpr_pkg::FRAME_COUNT_DEF,
    parameter int PAGE_BITS   = scpr_pkg::PAGE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [scpr_pkg::PAGE_W-1:0]   i_page_number,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_hit,
    output logic                          o_fault,
    output logic [scpr_pkg::FRAME_W-1:0]  o_frame_used,
    output logic                          o_evicted_valid,
    output logic [scpr_pkg::PAGE_W-1:0]   o_evicted_page,
    output logic [scpr_pkg::COUNT_W-1:0]  o_fault_total
);

    scpr_pkg::t_dp_cmd  cmd;
    scpr_pkg::t_dp_stat stat;

    scpr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    scpr_dp #(
        .FRAME_COUNT (FRAME_COUNT),
        .PAGE_BITS   (PAGE_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_page_number   (i_page_number),
        .i_ready         (i_ready),
        .o_valid         (o_valid),
        .o_hit           (o_hit),
        .o_fault         (o_fault),
        .o_frame_used    (o_frame_used),
        .o_evicted_valid (o_evicted_valid),
        .o_evicted_page  (o_evicted_page),
        .o_fault_total   (o_fault_total)
    );

endmodule

FILE: bench/tb_top.sv
// Self-checking testbench for the second-chance page replacer core.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAMES      = scpr_pkg::FRAME_COUNT_DEF;
    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_AT     = 1500;
    localparam int HOLD_LEN    = 300;
    localparam int CALM_LO     = 4000;
    localparam int CALM_HI     = 7000;
    localparam int RAND_REFS   = 1100;

    typedef struct packed {
        logic                         hit;
        logic                         fault;
        logic [scpr_pkg::FRAME_W-1:0] frame;
        logic                         evict_v;
        logic [scpr_pkg::PAGE_W-1:0]  evict_page;
        logic [scpr_pkg::COUNT_W-1:0] faults;
    } t_outcome;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_valid = 1'b0;
    logic                         o_ready;
    logic [scpr_pkg::PAGE_W-1:0]  i_page_number = '0;
    logic                         o_valid;
    logic                         i_ready = 1'b0;
    logic                         o_hit;
    logic                         o_fault;
    logic [scpr_pkg::FRAME_W-1:0] o_frame_used;
    logic                         o_evicted_valid;
    logic [scpr_pkg::PAGE_W-1:0]  o_evicted_page;
    logic [scpr_pkg::COUNT_W-1:0] o_fault_total;

    logic [scpr_pkg::PAGE_W-1:0]  page_refs[$];
    t_outcome                     pending_outcomes[$];

    logic [scpr_pkg::PAGE_W-1:0]  resident[FRAMES];
    bit                           occupied[FRAMES];
    bit                           refbit[FRAMES];
    int                           hand = 0;
    logic [scpr_pkg::COUNT_W-1:0] fault_cnt = '0;

    int  cyc = 0;
    int  stall_cycles = 0;
    int  mismatches = 0;
    bit  page_taken = 1'b0;
    wire calm = (cyc >= CALM_LO) && (cyc < CALM_HI);

    always #2 i_clk = ~i_clk;

    second_chance_page_replacer_core u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_page_number   (i_page_number),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_hit           (o_hit),
        .o_fault         (o_fault),
        .o_frame_used    (o_frame_used),
        .o_evicted_valid (o_evicted_valid),
        .o_evicted_page  (o_evicted_page),
        .o_fault_total   (o_fault_total)
    );

    function automatic t_outcome replace_page(input logic [scpr_pkg::PAGE_W-1:0] page);
        t_outcome res;
        bit       placed;
        int       f;
        int       guard;
        res    = '0;
        placed = 1'b0;
        for (f = 0; f < FRAMES; f++) begin
            if (!placed && occupied[f] && resident[f] == page) begin
                refbit[f] = 1'b1;
                res.frame = f[scpr_pkg::FRAME_W-1:0];
                res.hit   = 1'b1;
                placed    = 1'b1;
            end
        end
        if (!res.hit) begin
            for (f = 0; f < FRAMES; f++) begin
                if (!placed && !occupied[f]) begin
                    occupied[f] = 1'b1;
                    resident[f] = page;
                    refbit[f]   = 1'b0;
                    res.frame   = f[scpr_pkg::FRAME_W-1:0];
                    placed      = 1'b1;
                end
            end
            if (!placed) begin
                if (hand >= FRAMES) hand = 0;
                for (guard = 0; guard < 2 * FRAMES; guard++) begin
                    if (!refbit[hand]) break;
                    refbit[hand] = 1'b0;
                    hand = (hand + 1) % FRAMES;
                end
                res.frame      = hand[scpr_pkg::FRAME_W-1:0];
                res.evict_v    = 1'b1;
                res.evict_page = resident[hand];
                resident[hand] = page;
                refbit[hand]   = 1'b0;
                hand = (hand + 1) % FRAMES;
            end
            res.fault = 1'b1;
            if (fault_cnt != '1) fault_cnt = fault_cnt + 1'b1;
        end
        res.faults = fault_cnt;
        return res;
    endfunction

    task automatic check_field(input string name, input logic [scpr_pkg::COUNT_W-1:0] want,
                               input logic [scpr_pkg::COUNT_W-1:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    // sender
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_valid || page_taken)) begin
            if (page_refs.size() > 0 && (calm || $urandom_range(99) >= 8)) begin
                i_valid       <= 1'b1;
                i_page_number <= page_refs.pop_front();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver, with one long hold-off
    always @(negedge i_clk) begin : receiver
        int hold_left;
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_ready <= 1'b0;
        end else if (cyc == HOLD_AT) begin
            hold_left = HOLD_LEN;
            i_ready <= 1'b0;
        end else begin
            i_ready <= calm || ($urandom_range(99) >= 8);
        end
    end

    // monitor and scoreboard
    always @(posedge i_clk) begin : monitor
        t_outcome want;
        bit       in_beat;
        bit       out_beat;
        in_beat  = i_rst_n && i_valid && o_ready;
        out_beat = i_rst_n && o_valid && i_ready;
        cyc <= cyc + 1;
        page_taken <= in_beat;
        stall_cycles <= (in_beat || out_beat) ? 0 : stall_cycles + 1;
        if (in_beat) pending_outcomes.push_back(replace_page(i_page_number));
        if (out_beat) begin
            if (pending_outcomes.size() == 0) begin
                mismatches++;
                $display("%0t: result beat with nothing expected, page %0h frame %0d",
                         $time, o_evicted_page, o_frame_used);
            end else begin
                want = pending_outcomes.pop_front();
                check_field("hit", scpr_pkg::COUNT_W'(want.hit),
                            scpr_pkg::COUNT_W'(o_hit));
                check_field("fault", scpr_pkg::COUNT_W'(want.fault),
                            scpr_pkg::COUNT_W'(o_fault));
                check_field("frame_used", scpr_pkg::COUNT_W'(want.frame),
                            scpr_pkg::COUNT_W'(o_frame_used));
                check_field("evicted_valid", scpr_pkg::COUNT_W'(want.evict_v),
                            scpr_pkg::COUNT_W'(o_evicted_valid));
                check_field("evicted_page", scpr_pkg::COUNT_W'(want.evict_page),
                            scpr_pkg::COUNT_W'(o_evicted_page));
                check_field("fault_total", want.faults, o_fault_total);
            end
        end
    end

    initial begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        logic [scpr_pkg::PAGE_W-1:0] pool[8];
        int                          pool_n;
        int                          i;
        int                          k;
        for (k = 0; k < FRAMES; k++) begin
            occupied[k] = 1'b0;
            refbit[k]   = 1'b0;
            resident[k] = '0;
        end
        // fills, hits, full sweep, partial sweep, repeats
        page_refs = '{16'h0000, 16'hFFFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h8000,
                      16'h1234, 16'hFFFF, 16'h5555, 16'hAAAA, 16'hAAAA, 16'h0001,
                      16'h1234, 16'h7FFF, 16'hFFFE, 16'h7FFF, 16'h0001, 16'hFFFE,
                      16'h8000, 16'h0000, 16'h0000, 16'hFFFF};
        pool_n = 4;
        for (i = 0; i < RAND_REFS; i++) begin
            if (i % 50 == 0) begin
                pool_n = $urandom_range(2, 7);
                for (k = 0; k < 8; k++) begin
                    pool[k] = scpr_pkg::PAGE_W'($urandom_range(0, 65535));
                end
            end
            if ($urandom_range(99) < 15)
                page_refs.push_back(scpr_pkg::PAGE_W'($urandom_range(0, 65535)));
            else
                page_refs.push_back(pool[$urandom_range(0, pool_n - 1)]);
        end

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        do @(posedge i_clk);
        while (page_refs.size() != 0 || i_valid || pending_outcomes.size() != 0);
        repeat (20) @(posedge i_clk);

        if (mismatches == 0 && pending_outcomes.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+src
src/scpr_pkg.sv
src/scpr_ctrl.sv
src/scpr_dp.sv
src/second_chance_page_replacer_core.sv
bench/tb_top.sv
